[hdl/qedd_pkg.sv]
// Shared types, constants and the quadrature step table of the encoder decoder.
`timescale 1ns / 1ps
`default_nettype none

package qedd_pkg;

   localparam int SENSITIVITY_WIDTH = 8;
   localparam int DEBOUNCE_WIDTH    = 16;
   localparam int CSR_DATA_WIDTH    = 16;
   localparam int CSR_INDEX_WIDTH   = 1;
   localparam int POSITION_OUT_WIDTH = 32;
   localparam int REQ_DATA_WIDTH    = 8;
   localparam int RSP_DATA_WIDTH    = 40;

   localparam int DEFAULT_POSITION_WIDTH = 32;
   localparam int DEFAULT_HOLD_WIDTH     = 16;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [SENSITIVITY_WIDTH-1:0] SENSITIVITY_RESET = 8'd1;
   localparam logic [DEBOUNCE_WIDTH-1:0]    DEBOUNCE_RESET    = 16'd1000;
   localparam logic [1:0]                   PIN_STATE_RESET   = 2'b11;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SENSITIVITY = 1'b0,
      CSR_DEBOUNCE    = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STEP_NONE  = 2'd0,
      STEP_MINUS = 2'd1,
      STEP_PLUS  = 2'd2
   } step_code_type;

   // One step travelling from the front to the back.
   typedef struct packed {
      logic valid;
      logic plus;
   } qedd_step_type;

   // Quadrature transition from the last stable state to the new one.
   // States carry A in bit 1 and B in bit 0.
   function automatic step_code_type step_lookup(input logic [1:0] from_state,
                                                 input logic [1:0] to_state);
      step_code_type code;
      case ({from_state, to_state}) inside
         4'b0001, 4'b0111, 4'b1000, 4'b1110: code = STEP_PLUS;
         4'b0010, 4'b0100, 4'b1011, 4'b1101: code = STEP_MINUS;
         default:                            code = STEP_NONE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

[hdl/qedd_front.sv]
// Front end: pin sampling, debounce and step classification.
`timescale 1ns / 1ps
`default_nettype none

module qedd_front
   import qedd_pkg::*;
#(
   parameter int HOLD_WIDTH = DEFAULT_HOLD_WIDTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire logic                      pin_a,
   input  wire logic                      pin_b,
   input  wire logic [DEBOUNCE_WIDTH-1:0] debounce_ticks,
   output qedd_step_type                  step
);

   localparam int CMP_WIDTH = (HOLD_WIDTH > DEBOUNCE_WIDTH) ? HOLD_WIDTH : DEBOUNCE_WIDTH;

   logic [1:0]            read_ff, read_in;
   logic [1:0]            stable_ff, stable_in;
   logic                  pending_ff, pending_in;
   logic [HOLD_WIDTH-1:0] hold_ff, hold_in;

   logic [1:0]    sample;
   step_code_type code;

   always_comb begin
      sample     = {pin_a, pin_b};
      read_in    = read_ff;
      stable_in  = stable_ff;
      pending_in = pending_ff;
      hold_in    = hold_ff;
      code       = STEP_NONE;

      if (sample != read_ff) begin
         read_in    = sample;
         hold_in    = '0;
         pending_in = 1'b1;
      end else if (pending_ff && (hold_ff != '1)) begin
         hold_in = hold_ff + 1'b1;
      end

      if (pending_in && (CMP_WIDTH'(hold_in) >= CMP_WIDTH'(debounce_ticks))) begin
         if (read_in != stable_ff) begin
            code      = step_lookup(stable_ff, read_in);
            stable_in = read_in;
         end
         pending_in = 1'b0;
      end

      step.valid = accept && (code != STEP_NONE);
      step.plus  = (code == STEP_PLUS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_ff    <= PIN_STATE_RESET;
         stable_ff  <= PIN_STATE_RESET;
         pending_ff <= 1'b0;
         hold_ff    <= '0;
      end else if (accept) begin
         read_ff    <= read_in;
         stable_ff  <= stable_in;
         pending_ff <= pending_in;
         hold_ff    <= hold_in;
      end
   end

endmodule

`default_nettype wire

[hdl/qedd_queue.sv]
// Short step queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module qedd_queue
   import qedd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire qedd_step_type push,
   input  wire logic    pop,
   output qedd_step_type head,
   output logic         full
);

   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   logic                   dir_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   function automatic logic [PTR_WIDTH-1:0] ptr_next(input logic [PTR_WIDTH-1:0] ptr);
      return (ptr == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push.valid ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + COUNT_WIDTH'(push.valid) - COUNT_WIDTH'(pop);
      head.valid = (count_ff != '0);
      head.plus  = dir_ff[rd_ptr_ff];
      full       = (count_ff == COUNT_WIDTH'(QUEUE_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         dir_ff[wr_ptr_ff] <= push.plus;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(QUEUE_DEPTH))
      else $error("step queue holds more entries than its depth");

   assert property (@(posedge clock) disable iff (reset)
      (push.valid && full) |-> pop)
      else $error("step pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("step popped from an empty queue");

endmodule

`default_nettype wire

[hdl/qedd_back.sv]
// Back end: position counter, direction run counters and the result register.
`timescale 1ns / 1ps
`default_nettype none

module qedd_back
   import qedd_pkg::*;
#(
   parameter int POSITION_WIDTH = DEFAULT_POSITION_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire qedd_step_type                head,
   output logic                              pop,
   input  wire logic [SENSITIVITY_WIDTH-1:0] sensitivity,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]         rsp_tdata
);

   localparam int EXT_WIDTH = (POSITION_WIDTH > POSITION_OUT_WIDTH) ? POSITION_WIDTH
                                                                     : POSITION_OUT_WIDTH;

   logic [POSITION_WIDTH-1:0]    position_ff, position_in;
   logic [SENSITIVITY_WIDTH-1:0] minus_run_ff, minus_run_in;
   logic [SENSITIVITY_WIDTH-1:0] plus_run_ff, plus_run_in;
   logic                         out_valid_ff, out_valid_in;
   logic                         out_dir_ff;
   logic                         out_detent_ff, out_detent_in;
   logic [POSITION_OUT_WIDTH-1:0] out_position_ff;

   logic [SENSITIVITY_WIDTH:0]   run_next;
   logic [EXT_WIDTH-1:0]         position_ext;

   always_comb begin
      pop          = head.valid && (!out_valid_ff || rsp_tready);
      position_in  = head.plus ? position_ff + 1'b1 : position_ff - 1'b1;
      run_next     = head.plus ? {1'b0, plus_run_ff} + 1'b1 : {1'b0, minus_run_ff} + 1'b1;
      out_detent_in = (run_next >= {1'b0, sensitivity});
      minus_run_in = '0;
      plus_run_in  = '0;
      if (!out_detent_in) begin
         if (head.plus) begin
            plus_run_in = run_next[SENSITIVITY_WIDTH-1:0];
         end else begin
            minus_run_in = run_next[SENSITIVITY_WIDTH-1:0];
         end
      end
      position_ext = EXT_WIDTH'(position_in);
      out_valid_in = pop ? 1'b1 : (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         minus_run_ff <= '0;
         plus_run_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            position_ff  <= position_in;
            minus_run_ff <= minus_run_in;
            plus_run_ff  <= plus_run_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_dir_ff      <= head.plus;
         out_detent_ff   <= out_detent_in;
         out_position_ff <= position_ext[POSITION_OUT_WIDTH-1:0];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - POSITION_OUT_WIDTH - 2){1'b0}},
                        out_detent_ff, out_position_ff, out_dir_ff};

   assert property (@(posedge clock) disable iff (reset)
      pop |=> (position_ff == ($past(position_ff) + 1'b1)) ||
              (position_ff == ($past(position_ff) - 1'b1)))
      else $error("position moved by other than one step");

   assert property (@(posedge clock) disable iff (reset)
      (pop && head.plus) |=> (minus_run_ff == '0))
      else $error("minus run not cleared by a plus step");

   assert property (@(posedge clock) disable iff (reset)
      (pop && !head.plus) |=> (plus_run_ff == '0))
      else $error("plus run not cleared by a minus step");

endmodule

`default_nettype wire

[hdl/quadrature_encoder_debounced_decoder.sv]
// Top level of the debounced quadrature encoder decoder.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one sample of the encoder pins A and B per item and accepts
// an item in every clock cycle while its step queue has room; each step is
// queued, then registered. Any change of the pin state restarts a hold count,
// and once the state has held for debounce_ticks items the quadrature table
// turns the move from the last stable state into a step of minus one, none or
// plus one. Only a nonzero step gives a result item: its direction, the
// wrapped signed position after the step, and a detent flag raised whenever
// the run counter of that direction reaches the sensitivity setting (a step
// the other way clears that run). The front end debounces and classifies in
// the cycle an item arrives, a two-entry queue holds steps, and the back end
// updates the counters and loads the result register, so the input keeps
// flowing while a result waits to be taken. The sustained rate is one item
// per cycle; it drops only while the result side stalls long enough for the
// step queue to fill. The user must write registers through the csr port only
// while no item is in flight; the block does not enforce it.
module quadrature_encoder_debounced_decoder
   import qedd_pkg::*;
#(
   parameter int POSITION_WIDTH = DEFAULT_POSITION_WIDTH,
   parameter int HOLD_WIDTH     = DEFAULT_HOLD_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // Input channel: tdata holds pin_a in bit 0 and pin_b in bit 1, zero above.
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [REQ_DATA_WIDTH-1:0]  req_tdata,
   // Result channel: tdata holds step_dir in bit 0, position in bits 32:1 and
   // detent_event in bit 33, zero above.
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]       rsp_tdata,
   // Configuration write port.
   input  wire logic                       csr_wen,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [SENSITIVITY_WIDTH-1:0] sensitivity_ff;
   logic [DEBOUNCE_WIDTH-1:0]    debounce_ff;

   qedd_step_type push_step;
   qedd_step_type head_step;
   logic          queue_full;
   logic          pop;
   logic          accept;

   // Configuration registers; every index in the list names one register.
   always_ff @(posedge clock) begin
      if (reset) begin
         sensitivity_ff <= SENSITIVITY_RESET;
         debounce_ff    <= DEBOUNCE_RESET;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_SENSITIVITY: sensitivity_ff <= csr_wdata[SENSITIVITY_WIDTH-1:0];
            CSR_DEBOUNCE:    debounce_ff    <= csr_wdata[DEBOUNCE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // The front end only runs when an item is taken, and items are refused
   // while the step queue is full so that no step can be lost.
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   qedd_front #(
      .HOLD_WIDTH (HOLD_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .pin_a          (req_tdata[0]),
      .pin_b          (req_tdata[1]),
      .debounce_ticks (debounce_ff),
      .step           (push_step)
   );

   qedd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push_step),
      .pop   (pop),
      .head  (head_step),
      .full  (queue_full)
   );

   qedd_back #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head_step),
      .pop         (pop),
      .sensitivity (sensitivity_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire
